// File: rtl/signed_int_to_decimal_ascii_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the clocked, reset-qualified checks of the decimal converter.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// The condition must hold at every clock edge out of reset.
`define SIDA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SIDA_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg
// Widths, character codes and the pipeline word of the decimal converter.
// ----------------------------------------------------------------------------
package sida_pkg;

	localparam int VALUE_BITS = 32;
	localparam int DATA_W     = 32;
	localparam int CHAR_W     = 6;
	localparam int OUT_DATA_W = 8;

	// Decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1).
	function automatic int num_digits_f(input int bits);
		logic [63:0] v;
		int          n;
		v = 64'd1 << (bits - 1);
		n = 0;
		while (v != 64'd0) begin
			v = v / 64'd10;
			n = n + 1;
		end
		return n;
	endfunction

	localparam int NUM_DIGITS = num_digits_f(VALUE_BITS);
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int DIG_W      = $clog2(NUM_DIGITS);
	localparam int CNT_W      = $clog2(NUM_DIGITS + 1);

	// Double-dabble shift steps done in each pipeline stage.
	localparam int STEPS_PER_STAGE = 4;
	localparam int NUM_STAGES      = (VALUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

	typedef struct packed {
		logic                  neg;
		logic [BCD_W-1:0]      bcd;
		logic [VALUE_BITS-1:0] bin;
	} pipe_t;

endpackage

// File: rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// A number passes the sign and magnitude stage, the double-dabble stages, the
// serializer and the character register; its characters then follow at one per
// cycle when the output is not stalled. Numbers are paced by the serializer, by
// sign and digit count; the double-dabble pipeline takes one per cycle unless held.
// Reset clears all valid bits and the serializer; nothing is kept between items.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_assert.svh"

module signed_int_to_decimal_ascii (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [sida_pkg::DATA_W-1:0]     s_axis_tdata,  // [31:0] value
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [sida_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [5:0] character, [7:6] zero
	output logic                            m_axis_tlast   // last
);
	import sida_pkg::*;

	// Stage 0 holds sign and magnitude; stages 1..NUM_STAGES run double dabble.
	pipe_t dd_s   [0:NUM_STAGES];
	pipe_t dd_nxt [0:NUM_STAGES];
	logic  vld_s  [0:NUM_STAGES];
	logic  rdy    [0:NUM_STAGES];

	logic                    busy_q;
	logic                    neg_pend_q;
	logic [BCD_W-1:0]        digits_q;
	logic [CNT_W-1:0]        left_q;
	logic                    out_vld_q;
	logic [CHAR_W-1:0]       char_q;
	logic                    last_q;

	logic                    out_free;
	logic                    emit;
	logic                    ser_take;
	logic [DIG_W-1:0]        lead;
	logic [DIG_W-1:0]        spare;
	logic [BCD_W-1:0]        aligned;
	logic [CNT_W-1:0]        nd;

	// A stage may load when it is empty or its content moves on this cycle.
	always_comb begin
		rdy[NUM_STAGES] = !vld_s[NUM_STAGES] || ser_take;
		for (int k = NUM_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k + 1];
		end
	end

	assign s_axis_tready = rdy[0];

	always_comb begin
		logic [VALUE_BITS-1:0] raw;
		raw = s_axis_tdata[VALUE_BITS-1:0];
		dd_nxt[0].neg = raw[VALUE_BITS-1];
		// The most negative value wraps to 2^(VALUE_BITS-1), read as unsigned.
		dd_nxt[0].bin = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
		dd_nxt[0].bcd = '0;
	end

	for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_dd
		always_comb begin
			logic [BCD_W-1:0]      bcd;
			logic [VALUE_BITS-1:0] bin;
			bcd = dd_s[k - 1].bcd;
			bin = dd_s[k - 1].bin;
			for (int j = 0; j < STEPS_PER_STAGE; j++) begin
				if ((k - 1) * STEPS_PER_STAGE + j < VALUE_BITS) begin
					for (int d = 0; d < NUM_DIGITS; d++) begin
						if (bcd[4*d +: 4] >= 4'd5) begin
							bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
						end
					end
					{bcd, bin} = {bcd[BCD_W-2:0], bin, 1'b0};
				end
			end
			dd_nxt[k].neg = dd_s[k - 1].neg;
			dd_nxt[k].bcd = bcd;
			dd_nxt[k].bin = bin;
		end
	end

	for (genvar k = 0; k <= NUM_STAGES; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= (k == 0) ? s_axis_tvalid : vld_s[(k == 0) ? 0 : k - 1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				dd_s[k] <= dd_nxt[k];
			end
		end
	end

	// Find the leading nonzero digit and move it to the top of the word.
	always_comb begin
		lead = '0;
		for (int d = 1; d < NUM_DIGITS; d++) begin
			if (dd_s[NUM_STAGES].bcd[4*d +: 4] != 4'd0) begin
				lead = DIG_W'(d);
			end
		end
		spare   = DIG_W'(NUM_DIGITS - 1) - lead;
		aligned = dd_s[NUM_STAGES].bcd << {spare, 2'b00};
		nd      = CNT_W'(lead) + 1'b1;
	end

	assign out_free = !out_vld_q || m_axis_tready;
	assign emit     = out_free && busy_q;
	assign ser_take = !busy_q || (emit && !neg_pend_q && left_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			neg_pend_q <= 1'b0;
			left_q     <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_free) begin
				out_vld_q <= busy_q;
			end
			if (ser_take) begin
				busy_q     <= vld_s[NUM_STAGES];
				neg_pend_q <= dd_s[NUM_STAGES].neg;
				left_q     <= nd;
			end else if (emit) begin
				if (neg_pend_q) begin
					neg_pend_q <= 1'b0;
				end else begin
					left_q <= left_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (neg_pend_q) begin
				char_q <= ASCII_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= ASCII_ZERO + {2'b00, digits_q[BCD_W-1 -: 4]};
				last_q <= (left_q == CNT_W'(1));
			end
		end
		if (ser_take) begin
			digits_q <= aligned;
		end else if (emit && !neg_pend_q) begin
			digits_q <= {digits_q[BCD_W-5:0], 4'd0};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - CHAR_W){1'b0}}, char_q};
	assign m_axis_tlast  = last_q;

	`SIDA_ASSERT_IMPLY(a_char_code, m_axis_tvalid,
		(m_axis_tdata[5:0] == ASCII_MINUS) ||
		((m_axis_tdata[5:0] >= ASCII_ZERO) && (m_axis_tdata[5:0] <= ASCII_ZERO + 6'd9)),
		"character is neither a minus sign nor a digit")
	`SIDA_ASSERT_IMPLY(a_minus_not_last, m_axis_tvalid && m_axis_tdata[5:0] == ASCII_MINUS,
		!m_axis_tlast, "minus sign marked as the last character")
	`SIDA_ASSERT_IMPLY(a_busy_count, busy_q, left_q != '0,
		"serializer busy with no digits left")
	`SIDA_ASSERT_ALWAYS(a_count_range, left_q <= CNT_W'(NUM_DIGITS),
		"digit count exceeds the digit width")

endmodule
